// ===== design/ordered_list_stack_engine_top_macros.svh =====
// Assertion helpers for the top-level RTL; clk and rst_n are taken from the using module.
`ifndef ORDERED_LIST_STACK_ENGINE_TOP_MACROS_SVH
`define ORDERED_LIST_STACK_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OLSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define OLSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/olse_pkg.sv =====
package olse_pkg;

    // List capacity and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 8;
    localparam int FUNC_W   = 3;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_PUSH    = 3'd2,
        OP_POP     = 3'd3,
        OP_REVERSE = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // What every cell does this cycle
    typedef enum logic [2:0] {
        CM_HOLD,
        CM_INSERT,
        CM_REMOVE,
        CM_PUSH,
        CM_POP,
        CM_ROT
    } cell_mode_t;

    typedef enum logic {
        FS_IDLE,
        FS_REV
    } fsm_t;

    // Command broadcast to the whole row
    typedef struct packed {
        cell_mode_t              mode;
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0]        count;
        logic [CNT_W-1:0]        k;
    } cell_ctrl_t;

endpackage

// ===== design/ordered_list_stack_engine_top.sv =====
// The result beat appears in the cycle after the input beat is taken, held in an output register.
// Throughput: one item per cycle for insert, remove, push, pop and no-op codes, while the consumer takes each result.
// Reverse of n entries rotates the head back through the cell row, one step a cycle,
// into slots n-1 down to 1, and takes no further input beat until the last step.
// Reset (rst_n low, asynchronous) clears the entry count, sequencer and result valid;
// slot contents are not cleared and are never read before being written.
module ordered_list_stack_engine_top
    import olse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata: data_in[7:0]
    input  logic [7:0]  s_axis_tdata,
    // s_axis_tuser: func[2:0]
    input  logic [2:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // m_axis_tdata: data_out[7:0], count[12:8], zero pad[15:13]
    output logic [15:0] m_axis_tdata,
    // m_axis_tuser: found[0], status[2:1]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

`include "ordered_list_stack_engine_top_macros.svh"

    fsm_t                    state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] out_data_reg, out_data_next;
    logic                    out_found_reg, out_found_next;
    status_t                 out_status_reg, out_status_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;

    cell_ctrl_t              ctrl;
    logic signed [VAL_W-1:0] head;
    logic                    chain_found;
    logic                    in_fire;
    logic signed [VAL_W-1:0] data_in;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign data_in       = s_axis_tdata;
    assign s_axis_tready = (state_reg == FS_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign count_ext     = {{COUNT_W{1'b0}}, count_next};

    olse_chain u_chain (
        .clk   (clk),
        .ctrl  (ctrl),
        .head  (head),
        .found (chain_found)
    );

    // Decode the beat, drive the row and build the result
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        ctrl.mode       = CM_HOLD;
        ctrl.value      = data_in;
        ctrl.count      = count_reg;
        ctrl.k          = k_reg;
        out_data_next   = '0;
        out_found_next  = 1'b0;
        out_status_next = ST_OK;
        case (state_reg)
            FS_IDLE:
            begin
                if (in_fire)
                begin
                    case (func_t'(s_axis_tuser))
                        OP_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                                out_status_next = ST_FULL;
                            else
                            begin
                                ctrl.mode  = CM_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            ctrl.mode      = CM_REMOVE;
                            out_found_next = chain_found;
                            if (chain_found)
                                count_next = count_reg - 1'b1;
                        end
                        OP_PUSH:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                                out_status_next = ST_FULL;
                            else
                            begin
                                ctrl.mode  = CM_PUSH;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                                out_status_next = ST_EMPTY;
                            else
                            begin
                                ctrl.mode     = CM_POP;
                                out_data_next = head;
                                count_next    = count_reg - 1'b1;
                            end
                        end
                        OP_REVERSE:
                        begin
                            if (count_reg > CNT_W'(1))
                            begin
                                ctrl.mode  = CM_ROT;
                                ctrl.value = head;
                                ctrl.k     = count_reg - 1'b1;
                                if (count_reg > CNT_W'(2))
                                begin
                                    state_next = FS_REV;
                                    k_next     = count_reg - CNT_W'(2);
                                end
                            end
                        end
                        default:
                        begin
                            ctrl.mode = CM_HOLD;
                        end
                    endcase
                end
            end
            FS_REV:
            begin
                // Move the head to slot k, then shrink k
                ctrl.mode  = CM_ROT;
                ctrl.value = head;
                if (k_reg == CNT_W'(1))
                    state_next = FS_IDLE;
                else
                    k_next = k_reg - 1'b1;
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // Hold the result until the consumer takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_count_next = count_ext[COUNT_W-1:0];
        if (in_fire)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FS_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg   <= out_data_next;
            out_found_reg  <= out_found_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_count_reg, out_data_reg};
    assign m_axis_tuser  = {out_status_reg, out_found_reg};

    `OLSE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count over capacity")
    `OLSE_ASSERT_NOW(a_rev_stall, state_reg == FS_REV, !s_axis_tready, "input taken mid-reverse")
    `OLSE_ASSERT_NEXT(a_rev_count, state_reg == FS_REV, $stable(count_reg), "reverse moved count")
    `OLSE_ASSERT_NEXT(a_pop_empty,
        in_fire && (s_axis_tuser == OP_POP) && (count_reg == '0),
        out_status_reg == ST_EMPTY, "pop on empty list not flagged")

endmodule

// ===== design/olse_cell.sv =====
module olse_cell
    import olse_pkg::*;
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic [CNT_W-1:0]        idx,
    input  logic signed [VAL_W-1:0] left_val,
    input  logic signed [VAL_W-1:0] right_val,
    input  logic                    at_in,
    output logic                    at_out,
    output logic signed [VAL_W-1:0] val
);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;
    logic                    valid;
    logic                    flag;

    assign valid = (idx < ctrl.count);
    assign val   = val_reg;

    // Pick keep, load, take-left or take-right for this slot
    always_comb
    begin
        flag     = 1'b0;
        at_out   = at_in;
        val_next = val_reg;
        case (ctrl.mode)
            CM_INSERT:
            begin
                if (idx == '0)
                    flag = !valid || (val_reg > ctrl.value);
                else
                    flag = !valid || (val_reg >= ctrl.value);
                at_out = at_in || flag;
                if (at_in)
                    val_next = left_val;
                else if (flag)
                    val_next = ctrl.value;
            end
            CM_PUSH:
            begin
                at_out = 1'b1;
                if (at_in)
                    val_next = left_val;
                else
                    val_next = ctrl.value;
            end
            CM_REMOVE:
            begin
                flag   = valid && (val_reg == ctrl.value);
                at_out = at_in || flag;
                if (at_out)
                    val_next = right_val;
            end
            CM_POP:
            begin
                val_next = right_val;
            end
            CM_ROT:
            begin
                if (idx < ctrl.k)
                    val_next = right_val;
                else if (idx == ctrl.k)
                    val_next = ctrl.value;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== design/olse_chain.sv =====
module olse_chain
    import olse_pkg::*;
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    output logic signed [VAL_W-1:0] head,
    output logic                    found
);

    logic signed [VAL_W-1:0] vals [CAPACITY];
    logic                    at   [CAPACITY+1];

    assign at[0] = 1'b0;
    assign head  = vals[0];
    assign found = at[CAPACITY];

    // Wire each cell to its neighbors; the ends see zero and themselves
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_v;
        logic signed [VAL_W-1:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_l
            assign left_v = vals[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = vals[i];
        end
        else
        begin : g_mid_r
            assign right_v = vals[i+1];
        end

        olse_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .idx       (CNT_W'(i)),
            .left_val  (left_v),
            .right_val (right_v),
            .at_in     (at[i]),
            .at_out    (at[i+1]),
            .val       (vals[i])
        );
    end

endmodule

// ===== verif/ordered_list_stack_engine_top_test.sv =====
module ordered_list_stack_engine_top_test
    import olse_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Function codes with no operation behind them
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

    // Operation mixes for the random part
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_EVEN   = 2;
    localparam int CHUNK_LEN  = 20;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [VAL_W-1:0]  value;
    } list_cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] data_out;
        logic                    found;
        status_t                 status;
        logic [COUNT_W-1:0]      count;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;

    // Shadow copy of the list contents
    logic signed [VAL_W-1:0] list_vals [CAPACITY];
    int                      list_len = 0;

    list_cmd_t    ops_pending[$];
    list_result_t list_results_due[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           failed = 1'b0;

    ordered_list_stack_engine_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #6 clk = ~clk;

    // Shift entries up from pos and store v there
    function automatic void open_slot(int pos, logic signed [VAL_W-1:0] v);
        for (int i = list_len; i > pos; i--)
            list_vals[i] = list_vals[i-1];
        list_vals[pos] = v;
        list_len++;
    endfunction

    // Shift entries down over pos
    function automatic void close_slot(int pos);
        for (int i = pos; i + 1 < list_len; i++)
            list_vals[i] = list_vals[i+1];
        list_len--;
    endfunction

    // Apply one operation to the shadow list and return the result beat it causes
    function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] op,
                                                   logic signed [VAL_W-1:0] v);
        list_result_t r;
        int pos;
        int lo;
        int hi;
        logic signed [VAL_W-1:0] t;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else if (list_len == 0 || list_vals[0] > v)
                    open_slot(0, v);
                else
                begin
                    // an equal head stays in front; search from slot 1
                    pos = 1;
                    while (pos < list_len && list_vals[pos] < v)
                        pos++;
                    open_slot(pos, v);
                end
            end
            OP_REMOVE:
            begin
                for (pos = 0; pos < list_len; pos++)
                begin
                    if (list_vals[pos] == v)
                    begin
                        close_slot(pos);
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            OP_PUSH:
            begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                    open_slot(0, v);
            end
            OP_POP:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.data_out = list_vals[0];
                    close_slot(0);
                end
            end
            OP_REVERSE:
            begin
                lo = 0;
                hi = list_len - 1;
                while (lo < hi)
                begin
                    t = list_vals[lo];
                    list_vals[lo] = list_vals[hi];
                    list_vals[hi] = t;
                    lo++;
                    hi--;
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    // Sender: predict on each accepted beat, hold an unaccepted one, else maybe idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                list_results_due.push_back(apply_list_op(s_axis_tuser, s_axis_tdata));
                void'(ops_pending.pop_front());
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (ops_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= ops_pending[0].value;
                    s_axis_tuser  <= ops_pending[0].op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (list_results_due.size() == 0)
                begin
                    $error("result beat with no prediction waiting");
                    failed = 1'b1;
                end
                else
                begin
                    want = list_results_due.pop_front();
                    if (m_axis_tdata[7:0] !== want.data_out)
                    begin
                        $error("data_out: expected %0d, got %0d",
                               want.data_out, $signed(m_axis_tdata[7:0]));
                        failed = 1'b1;
                    end
                    if (m_axis_tdata[12:8] !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, m_axis_tdata[12:8]);
                        failed = 1'b1;
                    end
                    if (m_axis_tuser[0] !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, m_axis_tuser[0]);
                        failed = 1'b1;
                    end
                    if (m_axis_tuser[2:1] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser[2:1]);
                        failed = 1'b1;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_op(logic [FUNC_W-1:0] op, logic [VAL_W-1:0] v);
        list_cmd_t c;
        c.op = op;
        c.value = v;
        ops_pending.push_back(c);
    endtask

    // Queue random items in chunks that lean toward growing, shrinking or neither
    task automatic queue_random_ops(int n_items);
        int mix;
        int r;
        int sel;
        logic [FUNC_W-1:0] op;
        logic [VAL_W-1:0]  v;
        int lim [3][5];
        lim[MIX_GROW]   = '{45, 80, 88, 94, 98};
        lim[MIX_SHRINK] = '{10, 20, 55, 85, 93};
        lim[MIX_EVEN]   = '{25, 45, 65, 85, 95};
        mix = MIX_EVEN;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % CHUNK_LEN == 0)
                mix = $urandom_range(MIX_EVEN, MIX_GROW);
            r = $urandom_range(99);
            if (r < lim[mix][0])
                op = OP_INSERT;
            else if (r < lim[mix][1])
                op = OP_PUSH;
            else if (r < lim[mix][2])
                op = OP_REMOVE;
            else if (r < lim[mix][3])
                op = OP_POP;
            else if (r < lim[mix][4])
                op = OP_REVERSE;
            else
                op = FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
            // small values make duplicates and remove hits common
            sel = $urandom_range(3);
            case (sel)
                0: v = VAL_W'($urandom_range(8) - 4);
                1:
                begin
                    case ($urandom_range(3))
                        0: v = 8'h80;
                        1: v = 8'h7F;
                        2: v = 8'h81;
                        default: v = 8'h7E;
                    endcase
                end
                default: v = VAL_W'($urandom_range(255));
            endcase
            queue_op(op, v);
        end
    endtask

    // Wait until every queued operation has been sent and its result checked
    task automatic drain_all();
        while (ops_pending.size() != 0 || list_results_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        send_idle_pct = 35;
        recv_idle_pct = 88;

        // directed: empty list cases, equal head, extremes, every code
        queue_op(OP_POP, 8'h00);
        queue_op(OP_REMOVE, 8'h03);
        queue_op(OP_REVERSE, 8'h00);
        queue_op(OP_INSERT, 8'h0A);
        queue_op(OP_REVERSE, 8'hFF);
        queue_op(OP_INSERT, 8'h0A);
        queue_op(OP_INSERT, 8'h80);
        queue_op(OP_INSERT, 8'h7F);
        queue_op(OP_INSERT, 8'h80);
        queue_op(OP_INSERT, 8'h00);
        queue_op(OP_REMOVE, 8'h0A);
        queue_op(OP_REMOVE, 8'h37);
        queue_op(OP_PUSH, 8'hFF);
        queue_op(OP_PUSH, 8'h7F);
        queue_op(OP_REVERSE, 8'h55);
        queue_op(OP_POP, 8'hAA);
        queue_op(OP_POP, 8'h00);
        queue_op(FUNC_UNUSED_LO, 8'h12);
        queue_op(FUNC_UNUSED_LO + 3'd1, 8'hED);
        queue_op(FUNC_UNUSED_HI, 8'hFF);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_random_ops(230);
        drain_all();

        send_idle_pct = 88;
        recv_idle_pct = 35;
        queue_random_ops(230);
        drain_all();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_ops(240);
        drain_all();

        // allow for a stray late beat
        repeat (20) @(posedge clk);
        if (!failed)
            $display("ordered_list_stack_engine_top_test: PASS");
        else
            $display("ordered_list_stack_engine_top_test: FAIL");
        $finish;
    end

    initial
    begin
        #(400_000 * 12);
        $display("ordered_list_stack_engine_top_test: FAIL");
        $finish;
    end

endmodule
